@@ sv/sdrs_pkg.sv @@
// Shared types, constants and register codes for the serial DAC refresh scanner.
package sdrs_pkg;

    // Default sizes handed to the top level parameters.
    localparam int CHANNELS_DEF     = 8;
    localparam int CMD_BITS_DEF     = 4;
    localparam int DATA_BITS_DEF    = 12;
    localparam int SELECT_LINES_DEF = 4;

    // Fixed storage widths of the codes and of the configuration fields.
    localparam int CODE_W          = 12;
    localparam int CMD_NIB_W       = 4;
    localparam int LINE_W          = 2;
    localparam int MAPPED_CHANNELS = 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SELMAP_W   = 16;

    localparam logic [CFG_DATA_W-1:0] CMDS_RST   = 32'd1364283729;
    localparam logic [SELMAP_W-1:0]   SELMAP_RST = 16'd64080;

    // Register index, taken from address bit two.
    localparam logic REG_CMDS   = 1'b0;
    localparam logic REG_SELMAP = 1'b1;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Frame commands from the controller to the datapath, one step each.
    typedef struct packed {
        logic start_frame;
        logic drive_low;
        logic set_bit;
        logic clock_high;
        logic release_sel;
    } t_frame_cmd;

endpackage

@@ sv/serial_dac_refresh_scanner_core.sv @@
// The result word is registered at the edge that accepts the input word; one word per clock
// while i_out_ready is high, as the output register frees when its result word is taken.
// A serial frame spans 2*(CMD_BITS+DATA_BITS)+3 tick words, one frame step per tick.
// Reset: synchronous, active low; codes read as zero through per-channel valid bits,
// all channels start pending, so no clearing pass is needed and words are taken at once.
module serial_dac_refresh_scanner_core #(
    parameter int CHANNELS     = sdrs_pkg::CHANNELS_DEF,
    parameter int CMD_BITS     = sdrs_pkg::CMD_BITS_DEF,
    parameter int DATA_BITS    = sdrs_pkg::DATA_BITS_DEF,
    parameter int SELECT_LINES = sdrs_pkg::SELECT_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input words
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [2:0]                      i_channel,
    input  logic [sdrs_pkg::CODE_W-1:0]     i_code,
    // Result words
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_serial_clock,
    output logic                            o_serial_data,
    output logic [SELECT_LINES-1:0]         o_select_lines,
    output logic [sdrs_pkg::CODE_W-1:0]     o_read_code,
    output logic                            o_busy_res,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdrs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sdrs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sdrs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    import sdrs_pkg::*;

    localparam int CH_W = $clog2(CHANNELS);
    localparam int FB_W = $clog2(CMD_BITS + DATA_BITS + 1);

    logic            r_out_valid;
    logic            in_ready;
    logic            in_accept;
    logic            tick;
    logic            cfg_we;
    logic            pending;
    logic            busy;
    t_frame_cmd      frame_cmd;
    logic [CH_W-1:0] scan_index;
    logic [FB_W-1:0] bit_count;

    // Handshake: a new word enters whenever the result register is free or being taken.
    assign in_ready  = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && in_ready;
    assign tick      = in_accept && (i_op == OP_TICK);
    assign cfg_we    = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Scanner and frame sequencer.
    sdrs_ctrl #(
        .CHANNELS  (CHANNELS),
        .CMD_BITS  (CMD_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (tick),
        .i_pending    (pending),
        .o_cmd        (frame_cmd),
        .o_scan_index (scan_index),
        .o_bit_count  (bit_count),
        .o_busy       (busy)
    );

    // Storage and line drivers.
    sdrs_datapath #(
        .CHANNELS     (CHANNELS),
        .CMD_BITS     (CMD_BITS),
        .DATA_BITS    (DATA_BITS),
        .SELECT_LINES (SELECT_LINES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .i_code         (i_code),
        .i_cmd          (frame_cmd),
        .i_scan_index   (scan_index),
        .i_bit_count    (bit_count),
        .o_pending      (pending),
        .i_cfg_we       (cfg_we),
        .i_cfg_sel      (paddr[2]),
        .i_cfg_wdata    (pwdata),
        .o_cfg_rdata    (prdata),
        .o_serial_clock (o_serial_clock),
        .o_serial_data  (o_serial_data),
        .o_select_lines (o_select_lines),
        .o_read_code    (o_read_code)
    );

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_busy_res  = busy;
    assign pready      = 1'b1;

`ifndef SYNTHESIS
    // The serial clock only goes low inside a frame.
    a_clock_low_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_serial_clock |-> o_busy_res)
        else $error("serial clock low outside a frame");

    // Writes and reads leave the frame and the lines untouched.
    a_access_keeps_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op != OP_TICK) |=>
            ($stable(o_busy_res) && $stable(o_serial_clock) &&
             $stable(o_serial_data) && $stable(o_select_lines)))
        else $error("non-tick word changed the frame state");

    // Every accepted word leaves a result word behind.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted word produced no result word");
`endif

endmodule

@@ sv/sdrs_ram.sv @@
// Generic RAM with one write port and two registered, write-first read ports.
module sdrs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re_a,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; a write to the same address is passed through.
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= (i_we && i_waddr == i_raddr_a) ? i_wdata : r_mem[i_raddr_a];
        end
        r_rdata_b <= (i_we && i_waddr == i_raddr_b) ? i_wdata : r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ sv/sdrs_ctrl.sv @@
// Scanner and frame sequencer: walks the channels and steps each serial frame.
module sdrs_ctrl #(
    parameter int CHANNELS  = 8,
    parameter int CMD_BITS  = 4,
    parameter int DATA_BITS = 12,
    localparam int CH_W = $clog2(CHANNELS),
    localparam int FB_W = $clog2(CMD_BITS + DATA_BITS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_pending,
    output sdrs_pkg::t_frame_cmd o_cmd,
    output logic [CH_W-1:0]     o_scan_index,
    output logic [FB_W-1:0]     o_bit_count,
    output logic                o_busy
);

    import sdrs_pkg::*;

    localparam int FRAME_BITS = CMD_BITS + DATA_BITS;

    typedef enum logic [2:0] {
        ST_START,
        ST_NEXT,
        ST_SELECT,
        ST_SETBIT,
        ST_CLOCKHI,
        ST_RELEASE
    } t_state;

    t_state           r_state, n_state;
    logic [CH_W-1:0]  r_scan, n_scan;
    logic [FB_W-1:0]  r_bits, n_bits;
    logic [FB_W-1:0]  bits_inc;
    t_frame_cmd       cmd;

    assign bits_inc = r_bits + FB_W'(1);

    // Next state and frame commands for one tick.
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_bits  = r_bits;
        cmd     = '0;
        if (i_step) begin
            unique case (r_state)
                ST_START: begin
                    if (i_pending) begin
                        cmd.start_frame = 1'b1;
                        n_bits          = '0;
                        n_state         = ST_SELECT;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
                ST_SELECT: begin
                    cmd.drive_low = 1'b1;
                    n_state       = ST_SETBIT;
                end
                ST_SETBIT: begin
                    cmd.set_bit = 1'b1;
                    n_state     = ST_CLOCKHI;
                end
                ST_CLOCKHI: begin
                    cmd.clock_high = 1'b1;
                    n_bits         = bits_inc;
                    n_state        = (bits_inc >= FB_W'(FRAME_BITS)) ? ST_RELEASE : ST_SETBIT;
                end
                ST_RELEASE: begin
                    cmd.release_sel = 1'b1;
                    n_state         = ST_NEXT;
                end
                ST_NEXT: begin
                    n_scan  = (r_scan == CH_W'(CHANNELS - 1)) ? '0 : r_scan + CH_W'(1);
                    n_state = ST_START;
                end
                default: begin
                    n_state = ST_START;
                end
            endcase
        end
    end

    // State, scan position and bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_scan  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_bits  <= n_bits;
        end
    end

    assign o_cmd        = cmd;
    assign o_scan_index = r_scan;
    assign o_bit_count  = r_bits;
    assign o_busy       = (r_state == ST_SELECT) || (r_state == ST_SETBIT) ||
                          (r_state == ST_CLOCKHI) || (r_state == ST_RELEASE);

endmodule

@@ sv/sdrs_datapath.sv @@
// Channel codes, pending flags, configuration registers and serial line levels.
module sdrs_datapath #(
    parameter int CHANNELS     = 8,
    parameter int CMD_BITS     = 4,
    parameter int DATA_BITS    = 12,
    parameter int SELECT_LINES = 4,
    localparam int CH_W = $clog2(CHANNELS),
    localparam int FB_W = $clog2(CMD_BITS + DATA_BITS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_op,
    input  logic [2:0]                    i_channel,
    input  logic [sdrs_pkg::CODE_W-1:0]   i_code,
    input  sdrs_pkg::t_frame_cmd          i_cmd,
    input  logic [CH_W-1:0]               i_scan_index,
    input  logic [FB_W-1:0]               i_bit_count,
    output logic                          o_pending,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_sel,
    input  logic [sdrs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [sdrs_pkg::CFG_DATA_W-1:0] o_cfg_rdata,
    output logic                          o_serial_clock,
    output logic                          o_serial_data,
    output logic [SELECT_LINES-1:0]       o_select_lines,
    output logic [sdrs_pkg::CODE_W-1:0]   o_read_code
);

    import sdrs_pkg::*;

    localparam int FRAME_BITS = CMD_BITS + DATA_BITS;

    logic [CFG_DATA_W-1:0]   r_cmds;
    logic [SELMAP_W-1:0]     r_selmap;
    logic [CHANNELS-1:0]     r_code_valid;
    logic [CHANNELS-1:0]     r_pending;
    logic                    r_scan_valid;
    logic                    r_rd_hit;
    logic [CMD_NIB_W-1:0]    r_lcmd;
    logic                    r_clk_lvl;
    logic                    r_data_lvl;
    logic [SELECT_LINES-1:0] r_sel, n_sel;

    logic                    ch_in_range;
    logic [CH_W-1:0]         ch_addr;
    logic                    wr_en;
    logic                    rd_en;
    logic [CODE_W-1:0]       rd_q;
    logic [CODE_W-1:0]       scan_q;
    logic [CODE_W-1:0]       code_live;
    logic [CMD_NIB_W-1:0]    cmd_nib;
    logic [LINE_W-1:0]       line_num;
    logic [FB_W-1:0]         cmd_pos;
    logic [FB_W-1:0]         data_pos;
    logic                    frame_bit;

    // Input word decode.
    assign ch_in_range = 32'(i_channel) < CHANNELS;
    assign ch_addr     = CH_W'(i_channel);
    assign wr_en       = i_accept && (i_op == OP_WRITE) && ch_in_range;
    assign rd_en       = i_accept && (i_op == OP_READ) && ch_in_range;

    // Code storage: port A serves reads, port B follows the scan position.
    sdrs_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CHANNELS)
    ) u_codes (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (ch_addr),
        .i_wdata   (i_code),
        .i_re_a    (rd_en),
        .i_raddr_a (ch_addr),
        .o_rdata_a (rd_q),
        .i_raddr_b (i_scan_index),
        .o_rdata_b (scan_q)
    );

    // An entry never written reads as zero.
    assign code_live   = r_scan_valid ? scan_q : '0;
    assign o_read_code = r_rd_hit ? rd_q : '0;

    // Valid bits, pending flags and read qualifiers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_valid <= '0;
            r_pending    <= '1;
            r_scan_valid <= 1'b0;
            r_rd_hit     <= 1'b0;
        end else begin
            r_scan_valid <= r_code_valid[i_scan_index] || (wr_en && ch_addr == i_scan_index);
            if (i_accept) begin
                r_rd_hit <= rd_en && r_code_valid[ch_addr];
            end
            if (wr_en) begin
                r_code_valid[ch_addr] <= 1'b1;
                r_pending[ch_addr]    <= 1'b1;
            end
            if (i_cmd.release_sel) begin
                r_pending[i_scan_index] <= 1'b0;
            end
        end
    end

    assign o_pending = r_pending[i_scan_index];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmds   <= CMDS_RST;
            r_selmap <= SELMAP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_sel == REG_SELMAP) begin
                r_selmap <= i_cfg_wdata[SELMAP_W-1:0];
            end else begin
                r_cmds <= i_cfg_wdata;
            end
        end
    end

    assign o_cfg_rdata = (i_cfg_sel == REG_SELMAP) ?
                         {{(CFG_DATA_W - SELMAP_W){1'b0}}, r_selmap} : r_cmds;

    // Command nibble and select line of the scanned channel; unmapped ones get zero.
    always_comb begin
        cmd_nib  = '0;
        line_num = '0;
        for (int c = 0; c < MAPPED_CHANNELS; c++) begin
            if (32'(i_scan_index) == c) begin
                cmd_nib  = r_cmds[c*CMD_NIB_W +: CMD_NIB_W];
                line_num = r_selmap[c*LINE_W +: LINE_W];
            end
        end
    end

    // Frame bit: command MSB first, then the live code MSB first.
    always_comb begin
        cmd_pos   = FB_W'(CMD_BITS - 1) - i_bit_count;
        data_pos  = FB_W'(FRAME_BITS - 1) - i_bit_count;
        frame_bit = 1'b0;
        if (i_bit_count < FB_W'(CMD_BITS)) begin
            if (cmd_pos < FB_W'(CMD_NIB_W)) begin
                frame_bit = r_lcmd[cmd_pos[1:0]];
            end
        end else if (data_pos < FB_W'(CODE_W)) begin
            frame_bit = code_live[data_pos[3:0]];
        end
    end

    // Select vector update; a line number past the last line moves nothing.
    always_comb begin
        n_sel = r_sel;
        for (int s = 0; s < SELECT_LINES; s++) begin
            if (32'(line_num) == s) begin
                if (i_cmd.drive_low) begin
                    n_sel[s] = 1'b0;
                end
                if (i_cmd.release_sel) begin
                    n_sel[s] = 1'b1;
                end
            end
        end
    end

    // Line levels and latched command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_lvl  <= 1'b1;
            r_data_lvl <= 1'b0;
            r_sel      <= '1;
            r_lcmd     <= '0;
        end else begin
            r_sel <= n_sel;
            if (i_cmd.start_frame) begin
                r_lcmd <= cmd_nib;
            end
            if (i_cmd.set_bit) begin
                r_data_lvl <= frame_bit;
                r_clk_lvl  <= 1'b0;
            end
            if (i_cmd.clock_high) begin
                r_clk_lvl <= 1'b1;
            end
        end
    end

    assign o_serial_clock = r_clk_lvl;
    assign o_serial_data  = r_data_lvl;
    assign o_select_lines = r_sel;

endmodule

@@ bench/sdrs_frame_check.sv @@
// Checker that predicts and compares every result word of the serial DAC refresh scanner.
module sdrs_frame_check
    import sdrs_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [2:0]                  i_channel,
    input  logic [CODE_W-1:0]           i_code,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_serial_clock,
    input  logic                        i_serial_data,
    input  logic [SELECT_LINES_DEF-1:0] i_select_lines,
    input  logic [CODE_W-1:0]           i_read_code,
    input  logic                        i_busy_res,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [CFG_ADDR_W-1:0]       i_paddr,
    input  logic [CFG_DATA_W-1:0]       i_pwdata,
    input  logic [CFG_DATA_W-1:0]       i_prdata,
    input  logic                        i_pready,
    output int                          o_error_count,
    output int                          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN = CMD_BITS_DEF + DATA_BITS_DEF;

    typedef enum logic [1:0] {SC_PROBE, SC_SHIFT, SC_ADVANCE} t_scan_phase;
    typedef enum logic [2:0] {
        FR_OFF, FR_LOWER_CS, FR_PRESENT_BIT, FR_RAISE_CLK, FR_RAISE_CS
    } t_frame_phase;

    // One result word as seen on the output channel.
    typedef struct packed {
        logic                        sclk;
        logic                        sdata;
        logic [SELECT_LINES_DEF-1:0] cs_n;
        logic [CODE_W-1:0]           rd;
        logic                        busy;
    } t_dac_word;

    // Predicted register and scanner state.
    logic [CFG_DATA_W-1:0]       cmd_nibbles;
    logic [SELMAP_W-1:0]         line_map;
    logic [CODE_W-1:0]           codes [CHANNELS_DEF];
    logic                        dirty [CHANNELS_DEF];
    int unsigned                 scan_idx;
    t_scan_phase                 scan_ph;
    t_frame_phase                frame_ph;
    int unsigned                 bits_sent;
    logic [CMD_NIB_W-1:0]        cmd_latch;
    logic                        sclk_lvl;
    logic                        sdata_lvl;
    logic [SELECT_LINES_DEF-1:0] cs_lvl;

    t_dac_word expected_words[$];
    t_dac_word want;
    int        errors = 0;

    assign o_error_count = errors;

    function automatic void reset_model();
        cmd_nibbles = CMDS_RST;
        line_map    = SELMAP_RST;
        for (int i = 0; i < CHANNELS_DEF; i++) begin
            codes[i] = '0;
            dirty[i] = 1'b1;
        end
        scan_idx  = 0;
        scan_ph   = SC_PROBE;
        frame_ph  = FR_OFF;
        bits_sent = 0;
        cmd_latch = '0;
        sclk_lvl  = 1'b1;
        sdata_lvl = 1'b0;
        cs_lvl    = '1;
    endfunction

    function automatic logic [CMD_NIB_W-1:0] command_for(int unsigned ch);
        if (ch >= MAPPED_CHANNELS) return '0;
        return cmd_nibbles[ch*CMD_NIB_W +: CMD_NIB_W];
    endfunction

    // Lines outside the implemented select vector are left alone.
    function automatic void set_select(int unsigned ch, logic level);
        int unsigned line;
        line = (ch >= MAPPED_CHANNELS) ? 0 : line_map[ch*LINE_W +: LINE_W];
        if (line < SELECT_LINES_DEF) cs_lvl[line] = level;
    endfunction

    // Command bits first, then the live code, both MSB first.
    function automatic logic frame_bit_at(int unsigned idx);
        int unsigned pos;
        if (idx < CMD_BITS_DEF) begin
            pos = CMD_BITS_DEF - 1 - idx;
            return (pos < CMD_NIB_W) ? cmd_latch[pos] : 1'b0;
        end
        pos = DATA_BITS_DEF - 1 - (idx - CMD_BITS_DEF);
        return (pos < CODE_W) ? codes[scan_idx][pos] : 1'b0;
    endfunction

    function automatic void frame_step();
        case (frame_ph)
            FR_LOWER_CS: begin
                set_select(scan_idx, 1'b0);
                frame_ph = FR_PRESENT_BIT;
            end
            FR_PRESENT_BIT: begin
                sdata_lvl = frame_bit_at(bits_sent);
                sclk_lvl  = 1'b0;
                frame_ph  = FR_RAISE_CLK;
            end
            FR_RAISE_CLK: begin
                sclk_lvl  = 1'b1;
                bits_sent = bits_sent + 1;
                frame_ph  = (bits_sent >= FRAME_LEN) ? FR_RAISE_CS : FR_PRESENT_BIT;
            end
            FR_RAISE_CS: begin
                set_select(scan_idx, 1'b1);
                dirty[scan_idx] = 1'b0;
                frame_ph = FR_OFF;
            end
            default: frame_ph = FR_OFF;
        endcase
    endfunction

    function automatic void scanner_step();
        case (scan_ph)
            SC_PROBE: begin
                if (dirty[scan_idx]) begin
                    cmd_latch = command_for(scan_idx);
                    bits_sent = 0;
                    frame_ph  = FR_LOWER_CS;
                    scan_ph   = SC_SHIFT;
                end else begin
                    scan_ph = SC_ADVANCE;
                end
            end
            SC_SHIFT: begin
                frame_step();
                if (frame_ph == FR_OFF) scan_ph = SC_ADVANCE;
            end
            default: begin
                scan_idx = (scan_idx + 1 >= CHANNELS_DEF) ? 0 : scan_idx + 1;
                scan_ph  = SC_PROBE;
            end
        endcase
    endfunction

    // Applies one input word and returns the line levels that follow it.
    function automatic t_dac_word line_state_after(logic [1:0] op, logic [2:0] ch,
                                                   logic [CODE_W-1:0] cd);
        t_dac_word w;
        w.rd = '0;
        case (op)
            OP_TICK: scanner_step();
            OP_WRITE: begin
                if (ch < CHANNELS_DEF) begin
                    codes[ch] = cd;
                    dirty[ch] = 1'b1;
                end
            end
            OP_READ: begin
                if (ch < CHANNELS_DEF) w.rd = codes[ch];
            end
            default: ;
        endcase
        w.sclk  = sclk_lvl;
        w.sdata = sdata_lvl;
        w.cs_n  = cs_lvl;
        w.busy  = (frame_ph != FR_OFF);
        return w;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result words are checked before the word accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_words.delete();
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: result word with no word expected, actual %0h %0h %0h %0h %0h",
                             $time, i_serial_clock, i_serial_data, i_select_lines,
                             i_read_code, i_busy_res);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("serial_clock", want.sclk, i_serial_clock);
                    check_field("serial_data", want.sdata, i_serial_data);
                    check_field("select_lines", want.cs_n, i_select_lines);
                    check_field("read_code", want.rd, i_read_code);
                    check_field("busy_res", want.busy, i_busy_res);
                end
            end

            // Register accesses on the configuration port.
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[2])
                        REG_CMDS:   cmd_nibbles = i_pwdata;
                        REG_SELMAP: line_map = i_pwdata[SELMAP_W-1:0];
                        default: ;
                    endcase
                end else if (i_paddr[2] == REG_CMDS) begin
                    check_field("channel_commands", cmd_nibbles, i_prdata);
                end else begin
                    check_field("select_map", {16'b0, line_map}, i_prdata);
                end
            end

            if (i_in_valid && i_in_ready)
                expected_words.push_back(line_state_after(i_op, i_channel, i_code));

            o_outstanding <= expected_words.size();
        end
    end

endmodule

@@ bench/tb.sv @@
// Top of the serial DAC refresh scanner testbench: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdrs_pkg::*;

    // Op code three is not defined by the block and must be ignored.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] ADDR_CMDS   = {REG_CMDS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SELMAP = {REG_SELMAP, 2'b00};

    localparam int IDLE_PCT      = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 210;
    localparam int SETTLE_CYCLES = 8;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [1:0]                  i_op = OP_TICK;
    logic [2:0]                  i_channel = '0;
    logic [CODE_W-1:0]           i_code = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic                        o_serial_clock;
    logic                        o_serial_data;
    logic [SELECT_LINES_DEF-1:0] o_select_lines;
    logic [CODE_W-1:0]           o_read_code;
    logic                        o_busy_res;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]       paddr = '0;
    logic [CFG_DATA_W-1:0]       pwdata = '0;
    logic [CFG_DATA_W-1:0]       prdata;
    logic                        pready;

    int error_count;
    int outstanding;
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    int hold_left = 0;
    int stall_cycles = 0;

    serial_dac_refresh_scanner_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .i_code         (i_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_serial_clock (o_serial_clock),
        .o_serial_data  (o_serial_data),
        .o_select_lines (o_select_lines),
        .o_read_code    (o_read_code),
        .o_busy_res     (o_busy_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sdrs_frame_check frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .i_code         (i_code),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_serial_clock (o_serial_clock),
        .i_serial_data  (o_serial_data),
        .i_select_lines (o_select_lines),
        .i_read_code    (o_read_code),
        .i_busy_res     (o_busy_res),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_error_count  (error_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, or a long hold-off when one is requested.
    initial begin
        forever @(posedge i_clk) begin
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one word, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_word(input logic [1:0] op, input logic [2:0] ch,
                             input logic [CODE_W-1:0] cd);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_channel  <= ch;
        i_code     <= cd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stops offering words until every expected result word has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // One register access: setup cycle, access cycle, then select and enable are dropped again.
    task automatic reg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // New register setting while idle, read back, then random words mostly ticks.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] cmds,
                             input logic [SELMAP_W-1:0] map, input bit hold);
        int          counted;
        int unsigned pick;
        logic [1:0]  op;
        counted = 0;
        wait_drained();
        reg_access(1'b1, ADDR_CMDS, cmds);
        reg_access(1'b1, ADDR_SELMAP, {16'b0, map});
        reg_access(1'b0, ADDR_CMDS, '0);
        reg_access(1'b0, ADDR_SELMAP, '0);
        if (hold) hold_left = HOLD_CYCLES;
        while (counted < PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 68)      op = OP_TICK;
            else if (pick < 84) op = OP_WRITE;
            else if (pick < 95) op = OP_READ;
            else                op = OP_NONE;
            send_word(op, 3'($urandom_range(7)), CODE_W'($urandom_range(4095)));
            if (op != OP_NONE) counted++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: code extremes, every op, undefined op, write during a frame.
        send_word(OP_WRITE, 3'd0, 12'hFFF);
        send_word(OP_WRITE, 3'd7, 12'h000);
        send_word(OP_WRITE, 3'd3, 12'hA5A);
        send_word(OP_WRITE, 3'd5, 12'h800);
        send_word(OP_READ, 3'd0, 12'h000);
        send_word(OP_READ, 3'd7, 12'hFFF);
        send_word(OP_READ, 3'd3, 12'h000);
        send_word(OP_NONE, 3'd7, 12'hFFF);
        send_word(OP_NONE, 3'd0, 12'h000);
        repeat (4) send_word(OP_TICK, 3'd0, 12'h000);
        send_word(OP_WRITE, 3'd0, 12'h555);
        repeat (8) send_word(OP_TICK, 3'd7, 12'hFFF);
        send_word(OP_READ, 3'd0, 12'h000);

        // Register settings: reset values, both extremes, then random ones.
        run_phase(CMDS_RST, SELMAP_RST, 1'b0);
        run_phase('0, '0, 1'b0);
        run_phase('1, '1, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(CFG_DATA_W'($urandom), SELMAP_W'($urandom), 1'b0);
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
        run_phase(CFG_DATA_W'($urandom), SELMAP_W'($urandom), 1'b0);
        run_phase(CFG_DATA_W'($urandom), 16'hE4E4, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
